### hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define CHK_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Checked at every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

### hdl/ptls_pkg.sv
package ptls_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RED_SECONDS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_SECONDS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_YELLOW_SECONDS = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNTDOWN_FROM = 2'd3;

  // Register reset values.
  localparam logic [7:0] RED_SECONDS_RESET    = 8'd10;
  localparam logic [7:0] GREEN_SECONDS_RESET  = 8'd10;
  localparam logic [7:0] YELLOW_SECONDS_RESET = 8'd3;
  localparam logic [7:0] COUNTDOWN_FROM_RESET = 8'd5;

  // Light codes.
  localparam logic [1:0] LIGHT_RED    = 2'd0;
  localparam logic [1:0] LIGHT_GREEN  = 2'd1;
  localparam logic [1:0] LIGHT_YELLOW = 2'd2;
  localparam logic [1:0] LIGHT_UNUSED = 2'd3;

  // Item kinds.
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_PRESS = 1'b1;

  // Button sides as carried on the input.
  localparam logic BUTTON_SIDE_ONE = 1'b0;

  // Side codes held in the request state.
  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_ONE  = 2'd1;
  localparam logic [1:0] SIDE_TWO  = 2'd2;

  typedef struct packed {
    logic mode;
    logic button_side;
  } in_item_t;

  typedef struct packed {
    logic [1:0] light;
    logic       red_lamp;
    logic       green_lamp;
    logic       buzzer;
    logic       countdown_show;
    logic [7:0] countdown_value;
    logic       announce_state;
    logic       announce_request;
  } out_item_t;

endpackage

### hdl/pedestrian_traffic_light_sequencer.sv
// Pedestrian traffic light sequencer. Each input item is either a one-second
// tick or a button press, and each one produces exactly one result item that
// shows the light, lamp drives, buzzer level, seconds left and display flags
// after that event. The light state is updated and the result is loaded into
// the output register on the edge that accepts the item, so a new item can be
// taken every cycle; the input is held off only while a result sits in the
// output register and the receiver is not taking it. Durations and the
// countdown threshold are written through the configuration port; the user must
// write them only while the block is idle, as the block itself does not enforce
// it. A new red duration applies from the next entry into red or press during red.
module pedestrian_traffic_light_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ptls_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ptls_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ptls_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ptls_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [7:0] red_seconds;
  logic [7:0] green_seconds;
  logic [7:0] yellow_seconds;
  logic [7:0] countdown_from;

  logic [1:0] light_phase, light_phase_next;
  logic [7:0] seconds_left, seconds_left_next;
  logic [1:0] pending_side, pending_side_next;
  logic [1:0] red_started_by, red_started_by_next;
  logic       buzz_phase, buzz_phase_next;
  logic       buzzer_level, buzzer_level_next;

  ptls_pkg::out_item_t result_next;
  logic                in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_seconds    <= ptls_pkg::RED_SECONDS_RESET;
      green_seconds  <= ptls_pkg::GREEN_SECONDS_RESET;
      yellow_seconds <= ptls_pkg::YELLOW_SECONDS_RESET;
      countdown_from <= ptls_pkg::COUNTDOWN_FROM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptls_pkg::REG_RED_SECONDS:    red_seconds    <= cfg_data;
        ptls_pkg::REG_GREEN_SECONDS:  green_seconds  <= cfg_data;
        ptls_pkg::REG_YELLOW_SECONDS: yellow_seconds <= cfg_data;
        ptls_pkg::REG_COUNTDOWN_FROM: countdown_from <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic       is_red;
    logic [1:0] side_code;
    logic [7:0] sec_dec;
    logic [1:0] lt;
    logic       show;
    logic       ann_state;
    logic       ann_req;

    is_red    = (light_phase != ptls_pkg::LIGHT_GREEN) &&
                (light_phase != ptls_pkg::LIGHT_YELLOW);
    side_code = (in_data.button_side == ptls_pkg::BUTTON_SIDE_ONE) ?
                ptls_pkg::SIDE_ONE : ptls_pkg::SIDE_TWO;
    sec_dec   = (seconds_left == 8'd0) ? 8'd0 : seconds_left - 8'd1;

    light_phase_next    = light_phase;
    seconds_left_next   = seconds_left;
    pending_side_next   = pending_side;
    red_started_by_next = red_started_by;
    buzz_phase_next     = buzz_phase;
    buzzer_level_next   = buzzer_level;
    show                = 1'b0;
    ann_state           = 1'b0;
    ann_req             = 1'b0;

    if (in_data.mode == ptls_pkg::MODE_TICK) begin
      if (is_red) begin
        buzz_phase_next   = !buzz_phase;
        buzzer_level_next = !buzz_phase;
      end else begin
        buzzer_level_next = 1'b0;
      end
      seconds_left_next = sec_dec;
      // The countdown is only shown in a red phase that a pedestrian began.
      show = (red_started_by != ptls_pkg::SIDE_NONE) && is_red &&
             (sec_dec <= countdown_from) && (sec_dec != 8'd0);
      if (sec_dec == 8'd0) begin
        ann_state = 1'b1;
        if (light_phase == ptls_pkg::LIGHT_GREEN) begin
          light_phase_next  = ptls_pkg::LIGHT_YELLOW;
          seconds_left_next = yellow_seconds;
        end else if (light_phase == ptls_pkg::LIGHT_YELLOW) begin
          light_phase_next  = ptls_pkg::LIGHT_RED;
          seconds_left_next = red_seconds;
          if (pending_side != ptls_pkg::SIDE_NONE) begin
            red_started_by_next = pending_side;
          end
          pending_side_next = ptls_pkg::SIDE_NONE;
        end else begin
          light_phase_next    = ptls_pkg::LIGHT_GREEN;
          seconds_left_next   = green_seconds;
          red_started_by_next = ptls_pkg::SIDE_NONE;
          pending_side_next   = ptls_pkg::SIDE_NONE;
        end
      end
      // A waiting request cuts green short: the next tick moves to yellow.
      if (pending_side_next != ptls_pkg::SIDE_NONE &&
          light_phase_next == ptls_pkg::LIGHT_GREEN) begin
        seconds_left_next = 8'd0;
      end
    end else begin
      if (is_red) begin
        seconds_left_next   = red_seconds;
        red_started_by_next = side_code;
        ann_state           = 1'b1;
      end else begin
        if (pending_side == ptls_pkg::SIDE_NONE || side_code == ptls_pkg::SIDE_ONE) begin
          pending_side_next = side_code;
        end
        ann_req = 1'b1;
      end
    end

    lt = (light_phase_next == ptls_pkg::LIGHT_GREEN ||
          light_phase_next == ptls_pkg::LIGHT_YELLOW) ?
         light_phase_next : ptls_pkg::LIGHT_RED;

    result_next.light            = lt;
    result_next.red_lamp         = (lt != ptls_pkg::LIGHT_GREEN);
    result_next.green_lamp       = (lt != ptls_pkg::LIGHT_RED);
    result_next.buzzer           = buzzer_level_next;
    result_next.countdown_show   = show;
    result_next.countdown_value  = seconds_left_next;
    result_next.announce_state   = ann_state;
    result_next.announce_request = ann_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_phase    <= ptls_pkg::LIGHT_RED;
      seconds_left   <= ptls_pkg::RED_SECONDS_RESET;
      pending_side   <= ptls_pkg::SIDE_NONE;
      red_started_by <= ptls_pkg::SIDE_NONE;
      buzz_phase     <= 1'b0;
      buzzer_level   <= 1'b0;
    end else if (in_fire) begin
      light_phase    <= light_phase_next;
      seconds_left   <= seconds_left_next;
      pending_side   <= pending_side_next;
      red_started_by <= red_started_by_next;
      buzz_phase     <= buzz_phase_next;
      buzzer_level   <= buzzer_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result_next;
    end
  end

endmodule

### hdl/ptls_checker.sv
`include "assert_macros.svh"

module ptls_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ptls_pkg::out_item_t out_data
);

  logic lamps_ok;
  logic countdown_ok;

  assign lamps_ok     = (out_data.light != ptls_pkg::LIGHT_UNUSED) &&
                        (out_data.red_lamp == (out_data.light != ptls_pkg::LIGHT_GREEN)) &&
                        (out_data.green_lamp == (out_data.light != ptls_pkg::LIGHT_RED));
  assign countdown_ok = (out_data.light == ptls_pkg::LIGHT_RED) &&
                        (out_data.countdown_value != 8'd0) && !out_data.announce_request;

  // Every accepted item shows up as a result on the next cycle.
  `CHK_ASSERT(a_accept_gives_result, in_valid && in_ready |=> out_valid)

  // A result that is not taken stays put.
  `CHK_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // Lamp drives follow the light, and the unused light code never appears.
  `CHK_ASSERT(a_lamps_match_light, out_valid |-> lamps_ok)

  // The countdown is only flagged in red with seconds still left and no request announced.
  `CHK_ASSERT(a_countdown_in_red, out_valid && out_data.countdown_show |-> countdown_ok)

  // Reset empties the output register.
  `CHK_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid)

endmodule

bind pedestrian_traffic_light_sequencer ptls_checker u_ptls_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
